/* rtl/core/tcc_pkg.sv */
package tcc_pkg;

    // Default geometry of the console.
    localparam int DEF_COLUMNS   = 80;
    localparam int DEF_ROWS      = 25;
    localparam int DEF_TAB_WIDTH = 8;

    // Field widths of the stream words.
    localparam int ACTION_W  = 2;
    localparam int CODE_W    = 8;
    localparam int CADDR_W   = 11;
    localparam int ROW_FW    = 5;
    localparam int COL_FW    = 7;
    localparam int POS_FW    = 11;
    localparam int DATA_FW   = 16;
    localparam int ATTR_W    = 8;
    localparam int CFG_IDX_W = 1;

    // Stream word widths; the data words are padded to whole bytes.
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    // Character codes.
    localparam logic [CODE_W-1:0] CH_BACKSPACE  = 8'h08;
    localparam logic [CODE_W-1:0] CH_TAB        = 8'h09;
    localparam logic [CODE_W-1:0] CH_LF         = 8'h0A;
    localparam logic [CODE_W-1:0] CH_CR         = 8'h0D;
    localparam logic [CODE_W-1:0] CH_SPACE      = 8'h20;
    localparam logic [CODE_W-1:0] CH_LAST_PRINT = 8'h7F;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTR  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLANK_ATTR = 1'd1;
    localparam logic [ATTR_W-1:0]    TEXT_ATTR_RST  = 8'h07;
    localparam logic [ATTR_W-1:0]    BLANK_ATTR_RST = 8'h0F;

    // Controller states.
    typedef enum logic [2:0] {
        ST_WIPE,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_CLEAR,
        ST_FINISH
    } tcc_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic exec;
        logic wipe_step;
        logic scroll_step;
        logic load_out;
    } tcc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                scroll_req;
        logic                wipe_last;
        logic                scroll_last;
        logic                out_free;
    } tcc_stat_t;

endpackage

/* rtl/core/tcc_ctrl.sv */
module tcc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  tcc_pkg::tcc_stat_t stat,
    output tcc_pkg::tcc_cmd_t  cmd
);
    import tcc_pkg::*;

    tcc_state_t state_reg;
    tcc_state_t state_next;
    logic       accept;

    // A new word is taken when idle, or when the finished result leaves.
    assign s_tready = (state_reg == ST_IDLE) || ((state_reg == ST_FINISH) && stat.out_free);
    assign accept   = s_tvalid && s_tready;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_WIPE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_WIPE:
            begin
                if (stat.wipe_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (stat.action == ACT_CLEAR)
                begin
                    state_next = ST_CLEAR;
                end
                else if ((stat.action == ACT_PUT) && stat.scroll_req)
                begin
                    state_next = ST_SCROLL;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCROLL:
            begin
                if (stat.scroll_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_CLEAR:
            begin
                if (stat.wipe_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = accept ? ST_EXEC : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_WIPE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd             = '0;
        cmd.load_item   = accept;
        cmd.exec        = (state_reg == ST_EXEC);
        cmd.wipe_step   = (state_reg == ST_WIPE) || (state_reg == ST_CLEAR);
        cmd.scroll_step = (state_reg == ST_SCROLL);
        cmd.load_out    = (state_reg == ST_FINISH) && stat.out_free;
    end

endmodule

/* rtl/core/tcc_datapath.sv */
module tcc_datapath #(
    parameter int COLUMNS   = tcc_pkg::DEF_COLUMNS,
    parameter int ROWS      = tcc_pkg::DEF_ROWS,
    parameter int TAB_WIDTH = tcc_pkg::DEF_TAB_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tcc_pkg::tcc_cmd_t               cmd,
    output tcc_pkg::tcc_stat_t              stat,
    input  logic                            cfg_we,
    input  logic [tcc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tcc_pkg::ATTR_W-1:0]      cfg_data,
    input  logic [tcc_pkg::ACTION_W-1:0]    in_action,
    input  logic [tcc_pkg::CODE_W-1:0]      in_code,
    input  logic [tcc_pkg::CADDR_W-1:0]     in_addr,
    input  logic                            m_tready,
    output logic                            out_valid,
    output logic [tcc_pkg::ROW_FW-1:0]      out_row,
    output logic [tcc_pkg::COL_FW-1:0]      out_col,
    output logic [tcc_pkg::POS_FW-1:0]      out_pos,
    output logic [tcc_pkg::DATA_FW-1:0]     out_data
);
    import tcc_pkg::*;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int KEEP   = (ROWS - 2) * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int COLX_W = $clog2(COLUMNS + TAB_WIDTH + 1);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int PH_W   = $clog2(TAB_WIDTH);

    // Character store.
    logic [DATA_FW-1:0] mem [CELLS];

    logic [COL_W-1:0]    col_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [PH_W-1:0]     phase_reg;
    logic [ACTION_W-1:0] action_reg;
    logic [CODE_W-1:0]   code_reg;
    logic [CADDR_W-1:0]  addr_reg;
    logic [ATTR_W-1:0]   text_attr_reg;
    logic [ATTR_W-1:0]   blank_attr_reg;
    logic [ADDR_W-1:0]   cnt_reg;
    logic [DATA_FW-1:0]  rd_data_reg;
    logic                out_valid_reg;
    logic [ROW_FW-1:0]   out_row_reg;
    logic [COL_FW-1:0]   out_col_reg;
    logic [POS_FW-1:0]   out_pos_reg;
    logic [DATA_FW-1:0]  out_data_reg;

    logic [COLX_W-1:0]  col_w;
    logic [ROW_W-1:0]   row_w;
    logic [PH_W-1:0]    phase_w;
    logic               wr_cell;
    logic               is_bs;
    logic [CODE_W-1:0]  wr_char;
    logic [ADDR_W-1:0]  cell_pos;
    logic [ADDR_W-1:0]  cur_pos;
    logic               scroll_req;
    logic               in_range;
    logic [31:0]        addr_ext;
    logic [31:0]        row_ext;
    logic [31:0]        col_ext;
    logic [31:0]        pos_ext;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [DATA_FW-1:0] mem_wdata;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;

    // Linear cell index of a cursor position.
    function automatic logic [ADDR_W-1:0] lin_pos(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
        return ADDR_W'(ADDR_W'(r) * ADDR_W'(COLUMNS)) + ADDR_W'(c);
    endfunction

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_attr_reg  <= TEXT_ATTR_RST;
            blank_attr_reg <= BLANK_ATTR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TEXT_ATTR:  text_attr_reg  <= cfg_data;
                REG_BLANK_ATTR: blank_attr_reg <= cfg_data;
                default:        text_attr_reg  <= text_attr_reg;
            endcase
        end
    end

    // Input word latch.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            action_reg <= in_action;
            code_reg   <= in_code;
            addr_reg   <= in_addr;
        end
    end

    // Cursor movement for one put byte, followed by the column wrap.
    always_comb
    begin
        col_w   = COLX_W'(col_reg);
        row_w   = row_reg;
        phase_w = phase_reg;
        wr_cell = 1'b0;
        is_bs   = 1'b0;
        wr_char = code_reg;
        unique case (code_reg)
            CH_BACKSPACE:
            begin
                wr_cell = 1'b1;
                is_bs   = 1'b1;
                wr_char = CH_SPACE;
                if (col_reg != '0)
                begin
                    col_w   = COLX_W'(col_reg) - COLX_W'(1);
                    phase_w = (phase_reg == '0) ? PH_W'(TAB_WIDTH - 1) : phase_reg - PH_W'(1);
                end
                else if (row_reg != '0)
                begin
                    col_w   = COLX_W'(COLUMNS - 1);
                    row_w   = row_reg - ROW_W'(1);
                    phase_w = PH_W'((COLUMNS - 1) % TAB_WIDTH);
                end
            end
            CH_TAB:
            begin
                col_w   = COLX_W'(col_reg) + COLX_W'(TAB_WIDTH) - COLX_W'(phase_reg);
                phase_w = '0;
            end
            CH_CR:
            begin
                col_w   = '0;
                phase_w = '0;
            end
            CH_LF:
            begin
                col_w   = '0;
                phase_w = '0;
                row_w   = row_reg + ROW_W'(1);
            end
            default:
            begin
                if ((code_reg >= CH_SPACE) && (code_reg <= CH_LAST_PRINT))
                begin
                    wr_cell = 1'b1;
                    col_w   = COLX_W'(col_reg) + COLX_W'(1);
                    phase_w = (phase_reg == PH_W'(TAB_WIDTH - 1)) ? '0 : phase_reg + PH_W'(1);
                end
            end
        endcase
        if (col_w >= COLX_W'(COLUMNS))
        begin
            col_w   = '0;
            phase_w = '0;
            row_w   = row_w + ROW_W'(1);
        end
    end

    assign scroll_req = (row_w == ROW_W'(ROWS - 1));
    assign cell_pos   = is_bs ? lin_pos(row_w, col_w[COL_W-1:0]) : lin_pos(row_reg, col_reg);
    assign cur_pos    = lin_pos(row_reg, col_reg);
    assign addr_ext   = 32'(addr_reg);
    assign in_range   = addr_ext < 32'(CELLS);

    // Cursor registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            phase_reg <= '0;
        end
        else if (cmd.exec && (action_reg == ACT_PUT))
        begin
            col_reg   <= col_w[COL_W-1:0];
            row_reg   <= scroll_req ? ROW_W'(ROWS - 2) : row_w;
            phase_reg <= phase_w;
        end
        else if (cmd.exec && (action_reg == ACT_CLEAR))
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            phase_reg <= '0;
        end
    end

    // Sweep counter for clearing and scrolling.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.load_item)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.wipe_step || cmd.scroll_step)
        begin
            cnt_reg <= cnt_reg + ADDR_W'(1);
        end
    end

    // Store port selection. A scroll reads one row ahead of its writes.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cnt_reg;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = addr_ext[ADDR_W-1:0];
        if (cmd.wipe_step)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.scroll_step)
        begin
            mem_re    = (cnt_reg < ADDR_W'(KEEP));
            mem_raddr = cnt_reg + ADDR_W'(COLUMNS);
            mem_we    = (cnt_reg != '0);
            mem_waddr = cnt_reg - ADDR_W'(1);
            mem_wdata = (cnt_reg <= ADDR_W'(KEEP)) ? rd_data_reg : {blank_attr_reg, CH_SPACE};
        end
        else if (cmd.exec)
        begin
            mem_we    = (action_reg == ACT_PUT) && wr_cell;
            mem_waddr = cell_pos;
            mem_wdata = {text_attr_reg, wr_char};
            mem_re    = (action_reg == ACT_READ);
        end
    end

    // Character store, one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign row_ext = 32'(row_reg);
    assign col_ext = 32'(col_reg);
    assign pos_ext = 32'(cur_pos);

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_row_reg  <= row_ext[ROW_FW-1:0];
            out_col_reg  <= col_ext[COL_FW-1:0];
            out_pos_reg  <= pos_ext[POS_FW-1:0];
            out_data_reg <= ((action_reg == ACT_READ) && in_range) ? rd_data_reg : '0;
        end
    end

    // Status to the controller.
    always_comb
    begin
        stat             = '0;
        stat.action      = action_reg;
        stat.scroll_req  = scroll_req;
        stat.wipe_last   = (cnt_reg == ADDR_W'(CELLS - 1));
        stat.scroll_last = (cnt_reg == ADDR_W'(KEEP + COLUMNS));
        stat.out_free    = !out_valid_reg || m_tready;
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_pos   = out_pos_reg;
    assign out_data  = out_data_reg;

endmodule

/* rtl/core/text_console_cursor_engine.sv */
// A put without scroll, a read or an unused action goes from the input latch through
// the EXEC and FINISH states to the output register; a new word is taken in IDLE, or in
// FINISH as the last result is loaded out, and the output can stall. A scroll adds a sweep
// through the single write port of the store; a clear adds a sweep over every cell.
// After reset the store is zeroed by a sweep over every cell while s_tready stays low;
// configuration writes are taken throughout.
module text_console_cursor_engine #(
    parameter int COLUMNS   = tcc_pkg::DEF_COLUMNS,
    parameter int ROWS      = tcc_pkg::DEF_ROWS,
    parameter int TAB_WIDTH = tcc_pkg::DEF_TAB_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // char_code [7:0], cell_address [18:8], zero [23:19]
    input  logic [tcc_pkg::S_TDATA_W-1:0]   s_tdata,
    // action [1:0]
    input  logic [tcc_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // cursor_row [4:0], cursor_column [11:5], cursor_position [22:12],
    // read_data [38:23], zero [39]
    output logic [tcc_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_we,
    input  logic [tcc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tcc_pkg::ATTR_W-1:0]      cfg_data
);
    import tcc_pkg::*;

    tcc_cmd_t            cmd;
    tcc_stat_t           stat;
    logic [ROW_FW-1:0]   out_row;
    logic [COL_FW-1:0]   out_col;
    logic [POS_FW-1:0]   out_pos;
    logic [DATA_FW-1:0]  out_data;

    tcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tcc_datapath #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_action (s_tuser[ACTION_W-1:0]),
        .in_code   (s_tdata[CODE_W-1:0]),
        .in_addr   (s_tdata[CODE_W+CADDR_W-1:CODE_W]),
        .m_tready  (m_tready),
        .out_valid (m_tvalid),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_pos   (out_pos),
        .out_data  (out_data)
    );

    // Result word packing.
    assign m_tdata = {1'b0, out_data, out_pos, out_col, out_row};

endmodule

/* rtl/core/tcc_checker.sv */
module tcc_checker #(
    parameter int COLUMNS = tcc_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcc_pkg::DEF_ROWS
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [tcc_pkg::M_TDATA_W-1:0]   m_tdata
);
    import tcc_pkg::*;

    logic [31:0] row_val;
    logic [31:0] col_val;
    logic [31:0] pos_val;

    assign row_val = 32'(m_tdata[4:0]);
    assign col_val = 32'(m_tdata[11:5]);
    assign pos_val = 32'(m_tdata[22:12]);

    // A stalled result word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result word changed while stalled");

    // One word at a time: the cycle after a word is taken the input is closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken in back-to-back cycles");

    // The reported cursor stays on the visible area above the last row.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((row_val <= 32'(ROWS - 2)) && (col_val < 32'(COLUMNS))))
        else $error("cursor outside the screen");

    // The linear position agrees with row and column.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (((row_val * 32'(COLUMNS) + col_val) & 32'h7FF) == pos_val))
        else $error("cursor position does not match row and column");

endmodule

bind text_console_cursor_engine tcc_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
